@@ src/ele_pkg.sv @@
package ele_pkg;

  localparam int LINE_DEPTH  = 16;
  localparam int ADDR_W      = $clog2(LINE_DEPTH);
  localparam int LEN_W       = $clog2(LINE_DEPTH + 1);
  localparam int MAX_RESULTS = 45;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_KILL = 8'h15;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [4:0] line_length;
    logic [3:0] read_index;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [3:0] line_count;
    logic       last;
  } rsp_t;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_NEWLINE,
    CMD_ERASE,
    CMD_KILL,
    CMD_PRINT,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [7:0]        data;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
    logic              addr_ok;
  } cmd_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              armed;
    logic [ADDR_W-1:0] count;
    logic [LEN_W-1:0]  limit;
  } stat_t;

endpackage

@@ src/ele_ram.sv @@
module ele_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ele_front.sv @@
module ele_front (
  input  logic               req_valid,
  output logic               req_ready,
  input  ele_pkg::req_t      req,
  input  logic               q_full,
  output logic               push,
  output ele_pkg::cmd_item_t push_item
);
  import ele_pkg::*;

  logic keep;

  assign req_ready = !q_full;
  assign push      = req_valid && req_ready && keep;

  always_comb begin
    keep              = 1'b0;
    push_item.cmd     = CMD_PRINT;
    push_item.data    = req.rx_byte;
    push_item.len     = (req.line_length > 5'(LINE_DEPTH)) ? LEN_W'(LINE_DEPTH)
                                                           : LEN_W'(req.line_length);
    push_item.addr    = ADDR_W'(req.read_index);
    push_item.addr_ok = 32'(req.read_index) < 32'(LINE_DEPTH);
    case (req.req_type)
      REQ_START: begin
        keep          = req.line_length != 5'd0;
        push_item.cmd = CMD_START;
      end
      REQ_BYTE: begin
        keep = 1'b1;
        case (req.rx_byte)
          CH_CR, CH_LF:  push_item.cmd = CMD_NEWLINE;
          CH_BS, CH_DEL: push_item.cmd = CMD_ERASE;
          CH_KILL:       push_item.cmd = CMD_KILL;
          CH_TAB:        keep = 1'b0;
          default:       push_item.cmd = CMD_PRINT;
        endcase
      end
      REQ_READ: begin
        keep          = 1'b1;
        push_item.cmd = CMD_READ;
      end
      default: keep = 1'b0;
    endcase
  end

endmodule

@@ src/ele_queue.sv @@
module ele_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ele_pkg::cmd_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output ele_pkg::cmd_item_t head
);
  import ele_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  cmd_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [OCC_W-1:0] occ;

  assign full     = occ == OCC_W'(QUEUE_DEPTH);
  assign nonempty = occ != '0;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        occ <= occ + 1'b1;
      end else if (pop && !push) begin
        occ <= occ - 1'b1;
      end
    end
  end

endmodule

@@ src/ele_back.sv @@
module ele_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ele_pkg::cmd_item_t q_item,
  output logic               q_pop,
  output ele_pkg::mem_req_t  mem,
  input  logic [7:0]         rdata,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ele_pkg::rsp_t      rsp,
  output ele_pkg::stat_t     stat
);
  import ele_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CR,
    S_LF,
    S_DONE,
    S_BS1,
    S_SP,
    S_BS2,
    S_ECHO,
    S_READ
  } state_t;

  state_t            state;
  logic              armed;
  logic [ADDR_W-1:0] count;
  logic [LEN_W-1:0]  limit;
  logic              kill;
  cmd_item_t         cur;
  logic [RES_W-1:0]  nres;

  logic slot_free;
  logic can_emit;
  logic advance;
  logic cap_last;
  logic room;
  logic load;
  rsp_t rsp_next;

  assign slot_free = !rsp_valid || rsp_ready;
  assign can_emit  = 32'(nres) < MAX_RESULTS;
  // once the result limit is reached, keep editing but emit nothing
  assign advance   = slot_free || !can_emit;
  assign cap_last  = 32'(nres) == MAX_RESULTS - 1;
  assign room      = (32'(count) + 1) < 32'(limit);
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign load      = (state != S_IDLE) && advance && can_emit;

  assign stat.armed = armed;
  assign stat.count = count;
  assign stat.limit = limit;

  always_comb begin
    mem.we    = 1'b0;
    mem.waddr = count;
    mem.wdata = 8'h00;
    mem.re    = q_pop && (q_item.cmd == CMD_READ) && q_item.addr_ok;
    mem.raddr = q_item.addr;
    case (state)
      S_DONE: mem.we = advance;
      S_BS1: begin
        mem.we    = advance;
        mem.waddr = count - 1'b1;
      end
      S_ECHO: begin
        mem.we    = advance;
        mem.wdata = cur.data;
      end
      default: mem.we = 1'b0;
    endcase
  end

  always_comb begin
    rsp_next.kind       = KIND_ECHO;
    rsp_next.data_byte  = 8'h00;
    rsp_next.line_count = 4'd0;
    rsp_next.last       = cap_last;
    case (state)
      S_CR: rsp_next.data_byte = CH_CR;
      S_LF: rsp_next.data_byte = CH_LF;
      S_DONE: begin
        rsp_next.kind       = KIND_DONE;
        rsp_next.line_count = 4'(count);
        rsp_next.last       = 1'b1;
      end
      S_BS1: rsp_next.data_byte = CH_BS;
      S_SP:  rsp_next.data_byte = CH_SP;
      S_BS2: begin
        rsp_next.data_byte = CH_BS;
        rsp_next.last      = cap_last || !kill || count == '0;
      end
      S_ECHO: begin
        rsp_next.data_byte = cur.data;
        rsp_next.last      = 1'b1;
      end
      S_READ: begin
        rsp_next.kind      = KIND_READ;
        rsp_next.data_byte = cur.addr_ok ? rdata : 8'h00;
        rsp_next.last      = 1'b1;
      end
      default: rsp_next.last = cap_last;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      armed     <= 1'b0;
      count     <= '0;
      limit     <= LEN_W'(LINE_DEPTH);
      kill      <= 1'b0;
      nres      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
        nres      <= nres + 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur  <= q_item;
            nres <= '0;
            case (q_item.cmd)
              CMD_START: begin
                limit <= q_item.len;
                count <= '0;
                armed <= 1'b1;
              end
              CMD_NEWLINE: if (armed) state <= S_CR;
              CMD_ERASE: begin
                if (armed && count != '0) begin
                  kill  <= 1'b0;
                  state <= S_BS1;
                end
              end
              CMD_KILL: begin
                if (armed && count != '0) begin
                  kill  <= 1'b1;
                  state <= S_BS1;
                end
              end
              CMD_PRINT: if (armed && room) state <= S_ECHO;
              CMD_READ:  state <= S_READ;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_CR: begin
          if (advance) state <= S_LF;
        end
        S_LF: begin
          if (advance) state <= S_DONE;
        end
        S_DONE: begin
          if (advance) begin
            armed <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_BS1: begin
          if (advance) begin
            count <= count - 1'b1;
            state <= S_SP;
          end
        end
        S_SP: begin
          if (advance) state <= S_BS2;
        end
        S_BS2: begin
          if (advance) begin
            state <= (kill && count != '0) ? S_BS1 : S_IDLE;
          end
        end
        S_ECHO: begin
          if (advance) begin
            count <= count + 1'b1;
            state <= S_IDLE;
          end
        end
        S_READ: begin
          if (advance) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/echoing_line_editor.sv @@
// channel  | valid     | ready     | payload      | item
// ---------+-----------+-----------+--------------+-------------------------------
// request  | req_valid | req_ready | req (req_t)  | start, received byte or read
// result   | rsp_valid | rsp_ready | rsp (rsp_t)  | echo byte, line done, read data
//
// The front takes one request per cycle while the two-entry command queue has room.
// The back sequencer takes a start when idle, a byte echo in S_ECHO, a read in S_READ,
// a newline as CR, LF, line done, an erase as BS, SP, BS, a kill of n chars as n such
// groups. Results wait in the output register; a stalled result halts the sequencer
// and, once the queue fills, the front. Reset (rst, synchronous) disarms the editor,
// clears the count and sets the limit to the full line; the line store is not cleared.
module echoing_line_editor (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ele_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ele_pkg::rsp_t rsp
);
  import ele_pkg::*;

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_nonempty;
  cmd_item_t  push_item;
  cmd_item_t  q_head;
  mem_req_t   mem;
  logic [7:0] rdata;
  stat_t      stat;

  ele_front u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (push_item)
  );

  ele_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  ele_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_nonempty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .mem       (mem),
    .rdata     (rdata),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .stat      (stat)
  );

  ele_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  a_count_below_limit: assert property (@(posedge clk) disable iff (rst)
    32'(stat.count) < 32'(stat.limit))
    else $error("character count reached the line limit");

  // the line complete item follows the LF echo and is loaded as the editor disarms
  a_done_disarms: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind == KIND_DONE && $past(rsp.kind) == KIND_ECHO) |-> !stat.armed)
    else $error("editor still armed after line complete");

  a_single_results_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.kind == KIND_DONE || rsp.kind == KIND_READ)) |-> rsp.last)
    else $error("line complete or read result without last");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_nonempty)
    else $error("command queue popped while empty");

endmodule
